// File: sv/ndt_pkg.sv
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared sizes, codes and control types for the name keyed directory table.
// ----------------------------------------------------------------------------
package ndt_pkg;

    // table geometry
    localparam int ENTRIES     = 16;
    localparam int NAME_CHARS  = 8;
    localparam int SECTOR_BITS = 10;

    // fixed port widths
    localparam int KEY_W   = 64;
    localparam int FSEC_W  = 10;
    localparam int EIDX_W  = 4;

    // derived sizes
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ACT_FIND   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ndt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } ndt_stat_t;

    // keep the low NAME_CHARS bytes up to the first zero byte
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] out;
        logic             ended;
        out   = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (raw[8*i +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                out[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return out;
    endfunction

endpackage

// File: sv/name_keyed_directory_table.sv
// ----------------------------------------------------------------------------
// name_keyed_directory_table
// Directory of named entries with find, add and remove over a scanned table.
// ----------------------------------------------------------------------------
//  channel   handshake        beat payload
//  -------   --------------   --------------------------------------
//  request   start / busy     action, name_key, new_sector
//  result    done (strobe)    status, found_sector, entry_index
//
// Each request reads every entry through the single read port of the entry
// memory, one entry per cycle, then finishes the compare of the last entry
// and commits; busy drops after the commit, so a new request is taken only
// once the previous one has committed.
// done pulses for one cycle after the commit; the receiver cannot stall it.
// Reset clears all valid marks at once; keys and sectors need no clearing.
// ----------------------------------------------------------------------------
module name_keyed_directory_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [ndt_pkg::KEY_W-1:0]       name_key,
    input  logic [ndt_pkg::FSEC_W-1:0]      new_sector,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [ndt_pkg::FSEC_W-1:0]      found_sector,
    output logic [ndt_pkg::EIDX_W-1:0]      entry_index
);
    import ndt_pkg::*;

    ndt_cmd_t  cmd;
    ndt_stat_t stat;

    // sequencer
    ndt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // table and result datapath
    ndt_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .name_key     (name_key),
        .new_sector   (new_sector),
        .done         (done),
        .status       (status),
        .found_sector (found_sector),
        .entry_index  (entry_index)
    );

endmodule

// File: sv/ndt_ctrl.sv
// ----------------------------------------------------------------------------
// ndt_ctrl
// Sequencer: takes a request, runs the table scan, then commits the result.
// ----------------------------------------------------------------------------
module ndt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output ndt_pkg::ndt_cmd_t cmd,
    input  ndt_pkg::ndt_stat_t stat
);
    import ndt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: sv/ndt_dpath.sv
// ----------------------------------------------------------------------------
// ndt_dpath
// Entry store, scan pointer, match and free-slot trackers, result registers.
// ----------------------------------------------------------------------------
module ndt_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ndt_pkg::ndt_cmd_t               cmd,
    output ndt_pkg::ndt_stat_t              stat,
    input  logic [1:0]                      action,
    input  logic [ndt_pkg::KEY_W-1:0]       name_key,
    input  logic [ndt_pkg::FSEC_W-1:0]      new_sector,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [ndt_pkg::FSEC_W-1:0]      found_sector,
    output logic [ndt_pkg::EIDX_W-1:0]      entry_index
);
    import ndt_pkg::*;

    // entry store: keys and sectors in memory, valid marks in flops
    logic [KEY_W-1:0]       key_mem [ENTRIES];
    logic [SECTOR_BITS-1:0] sec_mem [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;

    // latched request
    action_t                act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [SECTOR_BITS-1:0] sec_reg;

    // scan pipeline
    logic [CNT_W-1:0]       ptr_reg;
    logic [CNT_W-1:0]       ptr_next;
    logic                   live_reg;
    logic                   live_next;
    logic [IDX_W-1:0]       stg_idx_reg;
    logic                   stg_vld_reg;
    logic [KEY_W-1:0]       rd_key_reg;
    logic [SECTOR_BITS-1:0] rd_sec_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;

    // trackers
    logic                   hit_reg;
    logic                   hit_next;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [IDX_W-1:0]       hit_idx_next;
    logic [SECTOR_BITS-1:0] hit_sec_reg;
    logic [SECTOR_BITS-1:0] hit_sec_next;
    logic                   free_reg;
    logic                   free_next;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [IDX_W-1:0]       free_idx_next;

    // result
    logic                   done_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [FSEC_W-1:0]      fsec_reg;
    logic [FSEC_W-1:0]      fsec_next;
    logic [EIDX_W-1:0]      eidx_reg;
    logic [EIDX_W-1:0]      eidx_next;
    logic                   wr_en;

    assign rd_addr        = ptr_reg[IDX_W-1:0];
    assign rd_en          = cmd.step && (ptr_reg < CNT_W'(ENTRIES));
    assign stat.scan_done = (ptr_reg == CNT_W'(ENTRIES)) && !live_reg;

    // scan pointer and compare stage
    always_comb
    begin
        ptr_next      = ptr_reg;
        live_next     = live_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_sec_next  = hit_sec_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (cmd.load)
        begin
            ptr_next  = '0;
            live_next = 1'b0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                live_next = rd_en;
                if (rd_en)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            if (live_reg)
            begin
                if (stg_vld_reg && (rd_key_reg == key_reg) && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = stg_idx_reg;
                    hit_sec_next = rd_sec_reg;
                end
                if (!stg_vld_reg && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = stg_idx_reg;
                end
            end
        end
    end

    // action outcome at commit
    always_comb
    begin
        valid_next  = valid_reg;
        status_next = ST_NOT_FOUND;
        fsec_next   = '0;
        eidx_next   = '0;
        wr_en       = 1'b0;
        case (act_reg)
            ACT_FIND:
            begin
                if (hit_reg)
                begin
                    status_next = ST_OK;
                    fsec_next   = FSEC_W'(hit_sec_reg);
                    eidx_next   = EIDX_W'(hit_idx_reg);
                end
            end
            ACT_ADD:
            begin
                if (hit_reg)
                begin
                    status_next = ST_PRESENT;
                end
                else if (free_reg)
                begin
                    status_next             = ST_OK;
                    eidx_next               = EIDX_W'(free_idx_reg);
                    valid_next[free_idx_reg] = 1'b1;
                    wr_en                   = cmd.commit;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    status_next             = ST_OK;
                    eidx_next               = EIDX_W'(hit_idx_reg);
                    valid_next[hit_idx_reg] = 1'b0;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            live_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            live_reg <= live_next;
            hit_reg  <= hit_next;
            free_reg <= free_next;
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_sec_reg  <= hit_sec_next;
        free_idx_reg <= free_idx_next;
        if (cmd.load)
        begin
            act_reg <= action_t'(action);
            key_reg <= normalize_key(name_key);
            sec_reg <= SECTOR_BITS'(new_sector);
        end
        if (rd_en)
        begin
            stg_idx_reg <= rd_addr;
            stg_vld_reg <= valid_reg[rd_addr];
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            fsec_reg   <= fsec_next;
            eidx_reg   <= eidx_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[free_idx_reg] <= key_reg;
            sec_mem[free_idx_reg] <= sec_reg;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_sec_reg <= sec_mem[rd_addr];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found_sector = fsec_reg;
    assign entry_index  = eidx_reg;

endmodule
